// ===== sv/rcdm_pkg.sv =====
// rcdm_pkg: shared types, constants and helper functions for the drive mixer
// used by every module of the rc differential drive mixer; no dependencies
package rcdm_pkg;

    localparam int unsigned MAX_SPEED_DEF = 255;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DZ     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_DZ   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TANK_R_DZ  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_FLOOR = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_TANK_MIN   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THR   = CFG_IDX_W'(6);

    localparam logic [10:0] CENTER_RST     = 11'd1500;
    localparam logic [8:0]  THR_DZ_RST     = 9'd75;
    localparam logic [8:0]  STEER_DZ_RST   = 9'd30;
    localparam logic [8:0]  TANK_R_DZ_RST  = 9'd25;
    localparam logic [9:0]  KNOB_FLOOR_RST = 10'd200;
    localparam logic [7:0]  TANK_MIN_RST   = 8'd20;
    localparam logic [11:0] MODE_THR_RST   = 12'd1600;

    // datapath widths
    localparam int unsigned PULSE_W  = 12;
    localparam int unsigned DEV_W    = 12;
    localparam int unsigned K_W      = 10;
    localparam int unsigned RMUL_W   = 9;
    localparam int unsigned P_W      = 22;
    localparam int unsigned P_LO_W   = 19;
    localparam int unsigned X_W      = 30;
    localparam int unsigned RAT_X_W  = 23;
    localparam int unsigned MUL_B_W  = 17;
    localparam int unsigned PROD_W   = X_W + MUL_B_W;
    localparam int unsigned CMP_W    = 17;

    localparam logic [PULSE_W-1:0] KNOB_BASE = PULSE_W'(1000);
    localparam logic [K_W-1:0]     KNOB_FULL = K_W'(1000);
    localparam logic [RMUL_W-1:0]  FULL_DEFL = RMUL_W'(500);

    // deflection * knob at or above this saturates the speed
    localparam logic [P_W-1:0] SAT_LIMIT = P_W'(500000);

    // x / 500000 as (x >> 5) / 15625, x / 500 as (x >> 2) / 125, by reciprocal
    localparam int unsigned        SCL_PRE_SHIFT = 5;
    localparam int unsigned        SCL_REC_SHIFT = 30;
    localparam logic [MUL_B_W-1:0] SCL_RECIP     = MUL_B_W'(68719);
    localparam logic [MUL_B_W-1:0] SCL_DIV       = MUL_B_W'(15625);
    localparam int unsigned        RAT_PRE_SHIFT = 2;
    localparam int unsigned        RAT_REC_SHIFT = 23;
    localparam logic [MUL_B_W-1:0] RAT_RECIP     = MUL_B_W'(67108);
    localparam logic [MUL_B_W-1:0] RAT_DIV       = MUL_B_W'(125);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef struct packed {
        logic [10:0] center_pulse;
        logic [8:0]  throttle_deadzone;
        logic [8:0]  steer_deadzone;
        logic [8:0]  tank_right_deadzone;
        logic [9:0]  knob_floor;
        logic [7:0]  tank_min_speed;
        logic [11:0] mode_threshold;
    } cfg_t;

    // one classified frame
    typedef struct packed {
        logic              arcade;
        logic              fwd;
        logic              rev;
        logic              lft;
        logic              rgt;
        logic [K_W-1:0]    k;
        logic [DEV_W-1:0]  dev0;
        logic [DEV_W-1:0]  dev1;
        logic [RMUL_W-1:0] rmul;
        dir_t              tdir_l;
        dir_t              tdir_r;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // p < c - dz without going negative
    function automatic logic below_band(logic [PULSE_W-1:0] p, logic [10:0] c,
                                        logic [8:0] dz);
        return ({1'b0, p} + {4'b0, dz}) < {2'b0, c};
    endfunction

    function automatic logic above_band(logic [PULSE_W-1:0] p, logic [10:0] c,
                                        logic [8:0] dz);
        return {1'b0, p} > ({2'b0, c} + {4'b0, dz});
    endfunction

    function automatic logic [DEV_W-1:0] abs_dev(logic [PULSE_W-1:0] p,
                                                 logic [10:0] c);
        logic [PULSE_W-1:0] cw;
        cw = {1'b0, c};
        return (p >= cw) ? DEV_W'(p - cw) : DEV_W'(cw - p);
    endfunction

    function automatic dir_t side_dir(logic [PULSE_W-1:0] p, logic [10:0] c,
                                      logic [8:0] dz);
        dir_t d;
        if (below_band(p, c, dz))
            d = DIR_FWD;
        else if (above_band(p, c, dz))
            d = DIR_BACK;
        else
            d = DIR_NONE;
        return d;
    endfunction

endpackage

// ===== sv/rcdm_in_if.sv =====
// rcdm_in_if: input channel carrying one radio frame per word
// standalone, no package dependencies
interface rcdm_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] throttle_pulse;
    logic [11:0] steer_pulse;
    logic [11:0] right_throttle_pulse;
    logic [11:0] knob_pulse;
    logic [11:0] mode;

    modport source (
        output valid, throttle_pulse, steer_pulse, right_throttle_pulse, knob_pulse, mode,
        input  ready
    );
    modport sink (
        input  valid, throttle_pulse, steer_pulse, right_throttle_pulse, knob_pulse, mode,
        output ready
    );
endinterface

// ===== sv/rcdm_out_if.sv =====
// rcdm_out_if: output channel carrying one motor command per word
// standalone, no package dependencies
interface rcdm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] right_dir;
    logic [7:0] right_speed;
    logic [1:0] left_dir;
    logic [7:0] left_speed;
    logic       motor_enable;

    modport source (
        output valid, right_dir, right_speed, left_dir, left_speed, motor_enable,
        input  ready
    );
    modport sink (
        input  valid, right_dir, right_speed, left_dir, left_speed, motor_enable,
        output ready
    );
endinterface

// ===== sv/rcdm_front.sv =====
// rcdm_front: accepts frames and classifies them into queue entries
// depends on rcdm_pkg and rcdm_in_if
module rcdm_front (
    rcdm_in_if.sink            frame,
    input  rcdm_pkg::cfg_t     cfg,
    input  rcdm_pkg::q_stat_t  q_stat,
    output logic               q_push,
    output rcdm_pkg::q_entry_t q_entry
);
    import rcdm_pkg::*;

    logic [10:0]        c;
    logic [K_W-1:0]     floor_k;
    logic [PULSE_W-1:0] k_lo;
    logic [PULSE_W-1:0] k_hi;
    logic [K_W-1:0]     k;
    logic [DEV_W-1:0]   dev_thr;
    logic [DEV_W-1:0]   dev_str;
    logic [DEV_W-1:0]   dev_rthr;
    logic [DEV_W-1:0]   turn;
    logic               arcade;

    assign c = cfg.center_pulse;

    always_comb
    begin
        floor_k = (cfg.knob_floor > KNOB_FULL) ? KNOB_FULL : cfg.knob_floor;
        k_lo    = KNOB_BASE + PULSE_W'(floor_k);
        k_hi    = KNOB_BASE + PULSE_W'(KNOB_FULL);
        if (frame.knob_pulse < k_lo)
            k = floor_k;
        else if (frame.knob_pulse > k_hi)
            k = KNOB_FULL;
        else
            k = K_W'(frame.knob_pulse - KNOB_BASE);
    end

    assign dev_thr  = abs_dev(frame.throttle_pulse, c);
    assign dev_str  = abs_dev(frame.steer_pulse, c);
    assign dev_rthr = abs_dev(frame.right_throttle_pulse, c);
    // steering inside its dead band counts as no turn
    assign turn     = (dev_str < DEV_W'(cfg.steer_deadzone)) ? '0 : dev_str;
    assign arcade   = frame.mode <= cfg.mode_threshold;

    always_comb
    begin
        q_entry.arcade = arcade;
        q_entry.fwd    = below_band(frame.throttle_pulse, c, cfg.throttle_deadzone);
        q_entry.rev    = above_band(frame.throttle_pulse, c, cfg.throttle_deadzone);
        q_entry.lft    = below_band(frame.steer_pulse, c, cfg.steer_deadzone);
        q_entry.rgt    = above_band(frame.steer_pulse, c, cfg.steer_deadzone);
        q_entry.k      = k;
        q_entry.dev0   = dev_thr;
        q_entry.dev1   = arcade ? turn : dev_rthr;
        q_entry.rmul   = (turn >= DEV_W'(FULL_DEFL)) ? '0
                                                     : RMUL_W'(DEV_W'(FULL_DEFL) - turn);
        q_entry.tdir_l = side_dir(frame.throttle_pulse, c, cfg.throttle_deadzone);
        q_entry.tdir_r = side_dir(frame.right_throttle_pulse, c, cfg.tank_right_deadzone);
    end

    assign frame.ready = !q_stat.full;
    assign q_push      = frame.valid && !q_stat.full;

endmodule

// ===== sv/rcdm_queue.sv =====
// rcdm_queue: short queue of classified frames between front and back
// depends on rcdm_pkg
module rcdm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rcdm_pkg::q_entry_t wr_data,
    input  logic               pop,
    output rcdm_pkg::q_entry_t rd_data,
    output rcdm_pkg::q_stat_t  stat
);
    import rcdm_pkg::*;

    q_entry_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/rcdm_back.sv =====
// rcdm_back: sequencer with one shared multiplier that scales speeds, applies
// the turn ratio and issues changed motor commands; depends on rcdm_pkg, rcdm_out_if
module rcdm_back #(
    parameter int unsigned MAX_SPEED = rcdm_pkg::MAX_SPEED_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcdm_pkg::cfg_t     cfg,
    input  rcdm_pkg::q_stat_t  q_stat,
    input  rcdm_pkg::q_entry_t q_entry,
    output logic               q_pop,
    rcdm_out_if.source         cmd
);
    import rcdm_pkg::*;

    localparam int unsigned          SPD_W   = $clog2(MAX_SPEED + 1);
    localparam logic [SPD_W-1:0]     MAX_SPD = SPD_W'(MAX_SPEED);
    localparam logic [MUL_B_W-1:0]   MAX_MUL = MUL_B_W'(MAX_SPEED);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MK,
        B_MMAX,
        B_REC,
        B_CHK,
        B_FIX,
        B_RMUL,
        B_CMP
    } state_t;

    typedef enum logic [1:0] {
        PH_L0,
        PH_L1,
        PH_RAT
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    q_entry_t          ent_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [X_W-1:0]    x_reg;
    logic [SPD_W-1:0]  q_reg;
    logic              sat_reg;
    logic [SPD_W-1:0]  spd0_reg;
    logic [SPD_W-1:0]  spd1_reg;
    logic [SPD_W-1:0]  rspd_reg;

    logic [1:0]        prev_rdir_reg;
    logic [7:0]        prev_rspd_reg;
    logic [1:0]        prev_ldir_reg;
    logic [7:0]        prev_lspd_reg;

    logic              out_valid_reg;
    logic [1:0]        out_rdir_reg;
    logic [7:0]        out_rspd_reg;
    logic [1:0]        out_ldir_reg;
    logic [7:0]        out_lspd_reg;
    logic              out_en_reg;

    logic              rat;
    logic [X_W-1:0]    mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [X_W-1:0]    x_sel;
    logic [SPD_W-1:0]  q_est;
    logic [MUL_B_W-1:0] div_sel;
    logic [X_W-1:0]    rem;
    logic [SPD_W-1:0]  q_fix;
    logic [SPD_W-1:0]  lane_res;
    logic              need_ratio;

    dir_t              a_dir;
    dir_t              b_dir;
    logic [SPD_W-1:0]  a_spd;
    logic [SPD_W-1:0]  b_spd;
    logic              go;
    logic              l_go;
    logic              r_go;
    logic [7:0]        a_spd8;
    logic [7:0]        b_spd8;
    logic              changed;
    logic              out_free;
    logic              out_load;

    assign rat     = phase_reg == PH_RAT;
    assign x_sel   = rat ? X_W'(prod_reg[RAT_PRE_SHIFT +: RAT_X_W])
                         : prod_reg[SCL_PRE_SHIFT +: X_W];
    assign q_est   = rat ? prod_reg[RAT_REC_SHIFT +: SPD_W] : prod_reg[SCL_REC_SHIFT +: SPD_W];
    assign div_sel = rat ? RAT_DIV : SCL_DIV;
    // reciprocal estimate is low by at most one
    assign rem     = x_reg - prod_reg[X_W-1:0];
    assign q_fix   = q_reg + SPD_W'(rem >= X_W'(div_sel));
    assign lane_res = sat_reg ? MAX_SPD : q_fix;

    assign need_ratio = ent_reg.arcade && (ent_reg.fwd || ent_reg.rev)
                        && (ent_reg.lft || ent_reg.rgt);

    always_comb
    begin
        case (state_reg)
            B_MK:
            begin
                mul_a = X_W'((phase_reg == PH_L0) ? ent_reg.dev0 : ent_reg.dev1);
                mul_b = MUL_B_W'(ent_reg.k);
            end
            B_MMAX:
            begin
                mul_a = X_W'(prod_reg[P_LO_W-1:0]);
                mul_b = MAX_MUL;
            end
            B_REC:
            begin
                mul_a = x_sel;
                mul_b = rat ? RAT_RECIP : SCL_RECIP;
            end
            B_CHK:
            begin
                mul_a = X_W'(q_est);
                mul_b = div_sel;
            end
            B_RMUL:
            begin
                mul_a = X_W'(spd0_reg);
                mul_b = MUL_B_W'(ent_reg.rmul);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // assemble the command from the lane results
    always_comb
    begin
        a_dir = DIR_NONE;
        b_dir = DIR_NONE;
        a_spd = '0;
        b_spd = '0;
        l_go  = CMP_W'(spd0_reg) > CMP_W'(cfg.tank_min_speed);
        r_go  = CMP_W'(spd1_reg) > CMP_W'(cfg.tank_min_speed);
        if (ent_reg.arcade)
        begin
            go = ent_reg.fwd || ent_reg.rev || ent_reg.lft || ent_reg.rgt;
            if (go)
            begin
                if (!(ent_reg.fwd || ent_reg.rev))
                begin
                    // spin in place
                    a_spd = spd1_reg;
                    b_spd = spd1_reg;
                    a_dir = ent_reg.lft ? DIR_FWD : DIR_BACK;
                    b_dir = ent_reg.lft ? DIR_BACK : DIR_FWD;
                end
                else
                begin
                    a_dir = ent_reg.fwd ? DIR_FWD : DIR_BACK;
                    b_dir = a_dir;
                    a_spd = ent_reg.rgt ? rspd_reg : spd0_reg;
                    b_spd = (!ent_reg.rgt && ent_reg.lft) ? rspd_reg : spd0_reg;
                end
            end
        end
        else
        begin
            go = l_go || r_go;
            if (l_go)
            begin
                b_dir = ent_reg.tdir_l;
                b_spd = spd0_reg;
            end
            if (r_go)
            begin
                a_dir = ent_reg.tdir_r;
                a_spd = spd1_reg;
            end
        end
        a_spd8  = 8'(a_spd);
        b_spd8  = 8'(b_spd);
        changed = (a_dir != prev_rdir_reg) || (a_spd8 != prev_rspd_reg)
                  || (b_dir != prev_ldir_reg) || (b_spd8 != prev_lspd_reg);
    end

    assign out_free = !out_valid_reg || cmd.ready;
    assign out_load = (state_reg == B_CMP) && changed && out_free;
    assign q_pop    = (state_reg == B_IDLE) && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            phase_reg     <= PH_L0;
            ent_reg       <= '0;
            prod_reg      <= '0;
            x_reg         <= '0;
            q_reg         <= '0;
            sat_reg       <= 1'b0;
            spd0_reg      <= '0;
            spd1_reg      <= '0;
            rspd_reg      <= '0;
            prev_rdir_reg <= DIR_NONE;
            prev_rspd_reg <= '0;
            prev_ldir_reg <= DIR_NONE;
            prev_lspd_reg <= '0;
            out_valid_reg <= 1'b0;
            out_rdir_reg  <= DIR_NONE;
            out_rspd_reg  <= '0;
            out_ldir_reg  <= DIR_NONE;
            out_lspd_reg  <= '0;
            out_en_reg    <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (cmd.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        ent_reg   <= q_entry;
                        phase_reg <= PH_L0;
                        state_reg <= B_MK;
                    end
                end
                B_MK:
                begin
                    state_reg <= B_MMAX;
                end
                B_MMAX:
                begin
                    sat_reg   <= prod_reg[P_W-1:0] >= SAT_LIMIT;
                    state_reg <= B_REC;
                end
                B_REC:
                begin
                    x_reg     <= x_sel;
                    state_reg <= B_CHK;
                end
                B_CHK:
                begin
                    q_reg     <= q_est;
                    state_reg <= B_FIX;
                end
                B_FIX:
                begin
                    case (phase_reg)
                        PH_L0:
                        begin
                            spd0_reg  <= lane_res;
                            phase_reg <= PH_L1;
                            state_reg <= B_MK;
                        end
                        PH_L1:
                        begin
                            spd1_reg <= lane_res;
                            if (need_ratio)
                            begin
                                phase_reg <= PH_RAT;
                                state_reg <= B_RMUL;
                            end
                            else
                                state_reg <= B_CMP;
                        end
                        default:
                        begin
                            rspd_reg  <= q_fix;
                            state_reg <= B_CMP;
                        end
                    endcase
                end
                B_RMUL:
                begin
                    state_reg <= B_REC;
                end
                B_CMP:
                begin
                    if (!changed)
                        state_reg <= B_IDLE;
                    else if (out_free)
                    begin
                        prev_rdir_reg <= a_dir;
                        prev_rspd_reg <= a_spd8;
                        prev_ldir_reg <= b_dir;
                        prev_lspd_reg <= b_spd8;
                        out_rdir_reg  <= a_dir;
                        out_rspd_reg  <= a_spd8;
                        out_ldir_reg  <= b_dir;
                        out_lspd_reg  <= b_spd8;
                        out_en_reg    <= go;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.right_dir    = out_rdir_reg;
    assign cmd.right_speed  = out_rspd_reg;
    assign cmd.left_dir     = out_ldir_reg;
    assign cmd.left_speed   = out_lspd_reg;
    assign cmd.motor_enable = out_en_reg;

endmodule

// ===== sv/rc_differential_drive_mixer_core.sv =====
// Differential drive mixer top level: configuration registers, front, queue, back
// depends on rcdm_pkg, rcdm_in_if, rcdm_out_if, rcdm_front, rcdm_queue, rcdm_back

// Mixes each radio frame (throttle, steer, right throttle, knob, mode) into a
// two-motor command, arcade or tank by the mode pulse, scaled by the knob and
// saturated at MAX_SPEED. A command word leaves only when a direction or speed
// differs from the last one sent. Frames are classified on entry and held in a
// two-deep queue, so up to two frames are taken while the mixer is busy. The
// mixing sequencer runs every multiply through one shared multiplier: each lane
// steps through MK, MMAX, REC, CHK and FIX, a proportional turn ratio adds RMUL,
// REC, CHK and FIX, and the output word may wait on ready. Configuration writes
// take effect at once and belong in idle time.
module rc_differential_drive_mixer_core #(
    parameter int unsigned MAX_SPEED = rcdm_pkg::MAX_SPEED_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcdm_pkg::CFG_DATA_W-1:0] cfg_data,
    rcdm_in_if.sink                         frame,
    rcdm_out_if.source                      cmd
);
    import rcdm_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push;
    logic     q_pop;
    q_entry_t q_wr_data;
    q_entry_t q_rd_data;
    q_stat_t  q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_pulse        <= CENTER_RST;
            cfg_reg.throttle_deadzone   <= THR_DZ_RST;
            cfg_reg.steer_deadzone      <= STEER_DZ_RST;
            cfg_reg.tank_right_deadzone <= TANK_R_DZ_RST;
            cfg_reg.knob_floor          <= KNOB_FLOOR_RST;
            cfg_reg.tank_min_speed      <= TANK_MIN_RST;
            cfg_reg.mode_threshold      <= MODE_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER:     cfg_reg.center_pulse        <= 11'(cfg_data);
                CFG_THR_DZ:     cfg_reg.throttle_deadzone   <= 9'(cfg_data);
                CFG_STEER_DZ:   cfg_reg.steer_deadzone      <= 9'(cfg_data);
                CFG_TANK_R_DZ:  cfg_reg.tank_right_deadzone <= 9'(cfg_data);
                CFG_KNOB_FLOOR: cfg_reg.knob_floor          <= 10'(cfg_data);
                CFG_TANK_MIN:   cfg_reg.tank_min_speed      <= 8'(cfg_data);
                CFG_MODE_THR:   cfg_reg.mode_threshold      <= 12'(cfg_data);
                default:        ;
            endcase
        end
    end

    rcdm_front u_front (
        .frame   (frame),
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_wr_data)
    );

    rcdm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    rcdm_back #(
        .MAX_SPEED (MAX_SPEED)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .q_entry (q_rd_data),
        .q_pop   (q_pop),
        .cmd     (cmd)
    );

`ifndef SYNTHESIS
    // the mixer only pops a queue that holds a frame
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    // a full queue must hold off the input side
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !frame.ready)
        else $error("frame channel ready while queue full");

    // a stop word carries no direction and no speed
    a_stop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.motor_enable) |->
            (cmd.right_dir == DIR_NONE && cmd.left_dir == DIR_NONE
             && cmd.right_speed == 8'd0 && cmd.left_speed == 8'd0))
        else $error("stop word with nonzero fields");
`endif

endmodule
